[sv/dkt_pkg.sv]
// Shared types and codes for the deduplicating key table.
package dkt_pkg;

    localparam int KEY_W   = 48;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;

    // Command codes carried in the request.
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_FIND   = 3'd2;
    localparam logic [2:0] CMD_GET    = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // Status codes returned with every result.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [KEY_W-1:0]   key_value;
        logic               key_type;
        logic [INDEX_W-1:0] entry_index;
    } dkt_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [INDEX_W-1:0] found_index;
        logic [KEY_W-1:0]   out_key;
        logic               out_type;
        logic [COUNT_W-1:0] entry_count;
    } dkt_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic match;
        logic commit;
    } dkt_ctrl_t;

endpackage

[sv/dkt_ctrl.sv]
// Controller state machine that sequences capture, match and commit.
module dkt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output dkt_pkg::dkt_ctrl_t ctrl
);
    import dkt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;
    logic   capture;

    assign capture = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (capture)
                begin
                    state_next = S_MATCH;
                    busy_next  = 1'b1;
                end
            end
            S_MATCH:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign ctrl.capture = capture;
    assign ctrl.match   = (state_reg == S_MATCH);
    assign ctrl.commit  = (state_reg == S_COMMIT);

endmodule

[sv/dkt_datapath.sv]
// Key cells, parallel compare, shift-down removal and result register.
module dkt_datapath #(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dkt_pkg::dkt_ctrl_t ctrl,
    input  dkt_pkg::dkt_req_t  req,
    output dkt_pkg::dkt_rsp_t  rsp
);
    import dkt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int ADR_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    logic [KEY_W-1:0]     key_reg [TABLE_DEPTH];
    logic                 type_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    dkt_req_t             req_reg;
    dkt_rsp_t             rsp_reg;
    dkt_rsp_t             rsp_next;

    // Match-stage registers.
    logic                 hit_reg;
    logic                 hit_next;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [IDX_W-1:0]     hit_idx_next;
    logic                 in_range_reg;
    logic [KEY_W-1:0]     rd_key_reg;
    logic                 rd_type_reg;

    logic [TABLE_DEPTH-1:0] match_vec;
    logic [ADR_W-1:0]     idx_ext;
    logic [IDX_W-1:0]     idx_addr;
    logic                 full;
    logic                 wr_en;
    logic                 shift_en;
    logic [IDX_W-1:0]     wr_addr;

    assign idx_ext  = ADR_W'(req_reg.entry_index);
    assign idx_addr = idx_ext[IDX_W-1:0];
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign wr_addr  = IDX_W'(count_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            req_reg <= req;
        end
    end

    // Every live cell compares its key against the request at once.
    generate
        for (genvar i = 0; i < TABLE_DEPTH; i++)
        begin : g_match
            assign match_vec[i] = (count_reg > CNT_W'(i)) &&
                                  (key_reg[i] == req_reg.key_value);
        end
    endgenerate

    // The lowest matching cell wins.
    always_comb
    begin
        hit_next     = 1'b0;
        hit_idx_next = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_next     = 1'b1;
                hit_idx_next = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.match)
        begin
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            in_range_reg <= (CMP_W'(req_reg.entry_index) < CMP_W'(count_reg));
            rd_key_reg   <= key_reg[idx_addr];
            rd_type_reg  <= type_reg[idx_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        wr_en      = 1'b0;
        shift_en   = 1'b0;
        rsp_next   = '0;
        case (req_reg.cmd)
            CMD_ADD:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else if (hit_reg)
                begin
                    rsp_next.status = ST_DUP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (!in_range_reg)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    shift_en   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_FIND:
            begin
                if (hit_reg)
                begin
                    rsp_next.found_index = INDEX_W'(hit_idx_reg);
                end
                else
                begin
                    rsp_next.status = ST_NOTFOUND;
                end
            end
            CMD_GET:
            begin
                if (in_range_reg)
                begin
                    rsp_next.out_key  = rd_key_reg;
                    rsp_next.out_type = rd_type_reg;
                end
                else
                begin
                    rsp_next.status = ST_RANGE;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.entry_count = COUNT_W'(count_next);
    end

    // Each cell loads a new key, takes its upper neighbor on removal, or holds.
    generate
        for (genvar i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            always_ff @(posedge clk)
            begin
                if (ctrl.commit && wr_en && (wr_addr == IDX_W'(i)))
                begin
                    key_reg[i]  <= req_reg.key_value;
                    type_reg[i] <= req_reg.key_type;
                end
                else if (ctrl.commit && shift_en && (IDX_W'(i) >= idx_addr))
                begin
                    if (i < TABLE_DEPTH - 1)
                    begin
                        key_reg[i]  <= key_reg[(i + 1) % TABLE_DEPTH];
                        type_reg[i] <= type_reg[(i + 1) % TABLE_DEPTH];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

[sv/dedup_key_table.sv]
// Top level of the deduplicating key table: controller plus datapath.
//
//  Channel   Ports                 Transfer happens when
//  -------   -------------------   ---------------------------------------
//  command   start, busy, req      rising edge with start high, busy low
//  result    done, rsp             rising edge ending the cycle done is high
//
// Each command goes from transfer to result in order: the request is
// captured at the transfer, every live cell compares its key in parallel
// and the lowest match is encoded, then the cells, count and result are
// updated. busy is high through the match and commit steps; done pulses for
// one cycle right after, and a new command may be transferred in that same
// cycle; none is taken while busy is high. Reset is asynchronous and active
// low; it empties the table by clearing the count, while the key cells keep
// what they hold. The receiver cannot stall, so a result is never held back.
module dedup_key_table #(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dkt_pkg::dkt_req_t req,
    output logic              done,
    output dkt_pkg::dkt_rsp_t rsp
);
    import dkt_pkg::*;

    // Command bundle from the controller into the datapath.
    dkt_ctrl_t ctrl;

    dkt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    dkt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .req   (req),
        .rsp   (rsp)
    );

    // A transfer always produces its result after the match and commit steps.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 busy ##1 done)
        else $error("result did not follow a command transfer");

    // A result is only ever shown after a working cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    // The strobe lands in an idle cycle, so the block is ready with it.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

endmodule
